### rtl/core/swdfm_pkg.sv
// ----------------------------------------------------------------------------
// swdfm_pkg
// shared types and codes of the single-wire debug frame master
// ----------------------------------------------------------------------------
package swdfm_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_START = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_BAD   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_REFUSED = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_HEADER  = 3'd3;
  localparam logic [2:0] ST_PARITY  = 3'd4;

  localparam logic [2:0] REG_SHORT   = 3'd0;
  localparam logic [2:0] REG_PERIOD  = 3'd1;
  localparam logic [2:0] REG_SAMPLE  = 3'd2;
  localparam logic [2:0] REG_GAP     = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic        line_in;
    logic [1:0]  opcode;
    logic [23:0] target_address;
    logic [7:0]  byte_count;
    logic [7:0]  load_byte;
  } in_item_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        read_last;
    logic        done_res;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [23:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [5:0]  short_phase;
    logic [7:0]  period;
    logic [7:0]  sample_off;
    logic [7:0]  pre_gap;
    logic [23:0] timeout;
  } timing_t;

endpackage

### rtl/core/swdfm_if.sv
// ----------------------------------------------------------------------------
// swdfm_if
// valid/ready channel carrying one item of a generic payload type
// ----------------------------------------------------------------------------
interface swdfm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/single_wire_debug_frame_master_top.sv
// ----------------------------------------------------------------------------
// single_wire_debug_frame_master_top
// tick-driven frame master for a single-wire open-drain debug line
// ----------------------------------------------------------------------------
// channels: in_ch carries one item per line tick, write-byte load or start;
// out_ch returns exactly one result item for every accepted input item;
// cfg_ch writes the five timing registers (index 0..4), always ready.
// each item is taken into an input register, worked through the frame
// sequencer combinationally and lands in a result register; throughput is
// one item per cycle while the receiver does not stall.
// the write buffer is a memory of WRITE_DEPTH bytes with a registered read;
// the next frame's buffer byte is fetched ahead so its data is ready when
// the frame loads.
// a stalled receiver holds the result register; the input register then
// keeps its item and in_ch.ready drops, so nothing is lost or repeated.
// reset (rst, synchronous) returns the sequencer to idle, the registers to
// their defaults, the line to released and the load pointer to zero; the
// buffer contents are not cleared.
// ----------------------------------------------------------------------------
module single_wire_debug_frame_master_top #(
  parameter int WRITE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  swdfm_if.sink   in_ch,
  swdfm_if.source out_ch,
  swdfm_if.sink   cfg_ch
);
  import swdfm_pkg::*;

  localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_GAP, PH_TX, PH_ACKWAIT, PH_ACKSAMP,
    PH_RXWAIT, PH_RXSAMP, PH_RXTAIL, PH_RXACK
  } phase_t;

  timing_t timing;
  swdfm_regs u_regs (.clk(clk), .rst(rst), .cfg(cfg_ch), .timing(timing));

  // input register and result register
  logic     iv;
  in_item_t ir;
  logic     ov;
  out_item_t orr;
  logic     adv;

  assign adv         = iv && (!ov || out_ch.ready);
  assign in_ch.ready = !iv || adv;
  assign out_ch.valid = ov;
  assign out_ch.data  = orr;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (in_ch.ready) iv <= in_ch.valid;
      if (adv) ov <= 1'b1;
      else if (out_ch.ready) ov <= 1'b0;
    end
    if (in_ch.ready && in_ch.valid) ir <= in_ch.data;
  end

  // sequencer state
  phase_t      phase;
  logic [23:0] tick_count;
  logic [3:0]  bit_index;
  logic [9:0]  shift_word;
  logic        parity_acc;
  logic [8:0]  frame_index;
  logic [1:0]  saved_opcode;
  logic [23:0] saved_address;
  logic [7:0]  saved_count;
  logic [7:0]  load_pointer;
  logic        line_prev;
  logic        drive_hold;

  phase_t      phase_next;
  logic [23:0] tick_next;
  logic [3:0]  bit_next;
  logic [9:0]  shift_next;
  logic        parity_next;
  logic [8:0]  frame_next;
  logic [7:0]  lp_next;
  logic        drive_next;
  out_item_t   res;
  logic        mem_we;

  // write buffer, read address is the frame that follows the current one
  logic [7:0]  mem [WRITE_DEPTH];
  logic [7:0]  mem_q;
  logic [AW-1:0] rd_addr;
  logic [8:0]  fetch_idx;

  always_comb begin
    fetch_idx = (phase_next == PH_IDLE) ? 9'd0 :
                ((frame_next >= 9'd5) ? frame_next - 9'd5 : 9'd0);
    rd_addr = AW'(fetch_idx % 9'(WRITE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(load_pointer)] <= ir.load_byte;
    mem_q <= mem[rd_addr];
  end

  // effective timing
  logic [7:0] per, shp, soff;
  always_comb begin
    per  = (timing.period == 8'd0) ? 8'd1 : timing.period;
    shp  = ({2'b0, timing.short_phase} > per) ? per : {2'b0, timing.short_phase};
    soff = (timing.sample_off == 8'd0) ? 8'd1 : timing.sample_off;
  end

  // combinational step
  logic [3:0]  nbits;
  logic        txb;
  logic [7:0]  low_len;
  logic [23:0] tinc;
  logic [8:0]  total;
  logic [8:0]  fv;
  logic        wend;
  logic        edge_seen;
  logic [8:0]  rxidx;

  always_comb begin
    phase_next  = phase;
    tick_next   = tick_count;
    bit_next    = bit_index;
    shift_next  = shift_word;
    parity_next = parity_acc;
    frame_next  = frame_index;
    lp_next     = load_pointer;
    drive_next  = drive_hold;
    mem_we      = 1'b0;
    res         = '0;
    nbits = 4'd0; txb = 1'b0; low_len = 8'd0; wend = 1'b0;
    tinc  = tick_count + 24'd1;
    edge_seen = line_prev && !ir.line_in;
    total = 9'd0; fv = 9'd0; rxidx = 9'd0;

    if (iv) begin
      case (ir.kind)
        KIND_TICK: begin
          drive_next = 1'b0;
          unique case (phase)
            PH_GAP: begin
              if (tick_count >= {16'd0, timing.pre_gap}) begin
                // load frame then first tx tick
                unique case (frame_index)
                  9'd0: fv = {7'd0, saved_opcode};
                  9'd1: fv = {1'b0, saved_count};
                  9'd2: fv = {1'b0, saved_address[23:16]};
                  9'd3: fv = {1'b0, saved_address[15:8]};
                  9'd4: fv = {1'b0, saved_address[7:0]};
                  default: fv = {1'b0, mem_q};
                endcase
                nbits = (frame_index == 9'd0) ? 4'd4 : 4'd9;
                txb = fv[4'(nbits - 4'd1)];
                low_len = txb ? shp : per - shp;
                drive_next = (8'd0 < low_len);
                phase_next = PH_TX;
                parity_next = 1'b0;
                shift_next = {1'b0, fv};
                if (8'd1 >= per) begin
                  parity_next = txb;
                  bit_next = 4'd1;
                  tick_next = 24'd0;
                end else begin
                  bit_next = 4'd0;
                  tick_next = 24'd1;
                end
              end else tick_next = tinc;
            end
            PH_TX: begin
              nbits = (frame_index == 9'd0) ? 4'd4 : 4'd9;
              txb = (bit_index < nbits) ? shift_word[4'(nbits - 4'd1 - bit_index)]
                                        : parity_acc;
              low_len = txb ? shp : per - shp;
              drive_next = (tick_count[7:0] < low_len);
              tick_next = tinc;
              if (tinc[7:0] >= per) begin
                if (bit_index < nbits) parity_next = parity_acc ^ txb;
                bit_next = bit_index + 4'd1;
                tick_next = 24'd0;
                if (bit_index + 4'd1 > nbits) phase_next = PH_ACKWAIT;
              end
            end
            PH_ACKWAIT, PH_RXWAIT: begin
              if (edge_seen) begin
                phase_next = (phase == PH_ACKWAIT) ? PH_ACKSAMP : PH_RXSAMP;
                tick_next = 24'd0;
              end else begin
                tick_next = tinc;
                if (tinc >= timing.timeout) begin
                  phase_next = PH_IDLE; tick_next = 24'd0; lp_next = 8'd0;
                  res.done_res = 1'b1; res.status = ST_TIMEOUT;
                end
              end
            end
            PH_ACKSAMP: begin
              tick_next = tinc;
              if (tinc >= {16'd0, soff}) begin
                tick_next = 24'd0;
                total = (saved_opcode == OP_RESET) ? 9'd1 :
                        (saved_opcode == OP_READ) ? 9'd5 : 9'd5 + {1'b0, saved_count};
                if (ir.line_in) begin
                  frame_next = frame_index + 9'd1;
                  if (frame_index + 9'd1 < total) phase_next = PH_GAP;
                  else if (saved_opcode == OP_READ && saved_count != 8'd0) begin
                    phase_next = PH_RXWAIT; bit_next = 4'd0;
                  end else begin
                    phase_next = PH_IDLE; lp_next = 8'd0;
                    res.done_res = 1'b1; res.status = ST_OK;
                  end
                end else if (frame_index == 9'd0) begin
                  phase_next = PH_IDLE; lp_next = 8'd0;
                  res.done_res = 1'b1; res.status = ST_REFUSED;
                end else phase_next = PH_GAP;
              end
            end
            PH_RXSAMP: begin
              tick_next = tinc;
              if (tinc >= {16'd0, soff}) begin
                shift_next = {shift_word[8:0], ir.line_in};
                bit_next = bit_index + 4'd1;
                if (bit_index == 4'd0 && !ir.line_in) begin
                  phase_next = PH_IDLE; tick_next = 24'd0; lp_next = 8'd0;
                  res.done_res = 1'b1; res.status = ST_HEADER;
                end else if (bit_index + 4'd1 < 4'd10) begin
                  phase_next = PH_RXWAIT; tick_next = 24'd0;
                end else begin
                  parity_next = ^{shift_word[7:0], ir.line_in};
                  phase_next = PH_RXTAIL;
                end
              end
            end
            PH_RXTAIL, PH_RXACK: begin
              tick_next = tinc;
              if (phase == PH_RXACK || tinc >= {16'd0, per}) begin
                if (phase == PH_RXTAIL) tick_next = 24'd0;
                low_len = !parity_acc ? shp : per - shp;
                drive_next = (phase == PH_RXTAIL) ? (8'd0 < low_len)
                                                  : (tick_count[7:0] < low_len);
                tick_next = (phase == PH_RXTAIL) ? 24'd1 : tinc;
                phase_next = PH_RXACK;
                if (tick_next[7:0] >= per) begin
                  if (parity_acc) begin
                    phase_next = PH_IDLE; tick_next = 24'd0; lp_next = 8'd0;
                    res.done_res = 1'b1; res.status = ST_PARITY;
                  end else begin
                    rxidx = frame_index - 9'd5;
                    res.read_valid = 1'b1;
                    res.read_data = shift_word[8:1];
                    frame_next = frame_index + 9'd1;
                    if (rxidx + 9'd1 >= {1'b0, saved_count}) begin
                      res.read_last = 1'b1;
                      phase_next = PH_IDLE; tick_next = 24'd0; lp_next = 8'd0;
                      res.done_res = 1'b1; res.status = ST_OK;
                    end else begin
                      phase_next = PH_RXWAIT; tick_next = 24'd0; bit_next = 4'd0;
                    end
                  end
                end
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end
        KIND_LOAD: begin
          if (phase == PH_IDLE) begin
            mem_we = 1'b1;
            lp_next = (load_pointer == 8'(WRITE_DEPTH - 1)) ? 8'd0
                                                            : load_pointer + 8'd1;
          end
        end
        KIND_START: begin
          if (phase == PH_IDLE) begin
            if (ir.opcode == OP_BAD) begin
              tick_next = 24'd0; lp_next = 8'd0;
              res.done_res = 1'b1; res.status = ST_REFUSED;
            end else begin
              frame_next = 9'd0; tick_next = 24'd0; phase_next = PH_GAP;
            end
          end
        end
        default: ;
      endcase
    end
    res.drive_low = drive_next;
    res.busy_res  = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tick_count <= '0; bit_index <= '0; shift_word <= '0; parity_acc <= 1'b0;
      frame_index <= '0; saved_opcode <= '0; saved_address <= '0;
      saved_count <= '0; load_pointer <= '0; line_prev <= 1'b1;
      drive_hold <= 1'b0;
    end else if (adv) begin
      phase <= phase_next;
      tick_count <= tick_next;
      bit_index <= bit_next;
      shift_word <= shift_next;
      parity_acc <= parity_next;
      frame_index <= frame_next;
      load_pointer <= lp_next;
      drive_hold <= drive_next;
      if (ir.kind == KIND_TICK) line_prev <= ir.line_in;
      if (ir.kind == KIND_START && phase == PH_IDLE && ir.opcode != OP_BAD) begin
        saved_opcode <= ir.opcode;
        saved_address <= ir.target_address;
        saved_count <= ir.byte_count;
      end
    end
    if (adv) orr <= res;
  end
endmodule

### rtl/core/swdfm_regs.sv
// ----------------------------------------------------------------------------
// swdfm_regs
// timing configuration registers
// ----------------------------------------------------------------------------
module swdfm_regs (
  input  logic                 clk,
  input  logic                 rst,
  swdfm_if.sink                cfg,
  output swdfm_pkg::timing_t   timing
);
  import swdfm_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.short_phase <= 6'd2;
      timing.period      <= 8'd22;
      timing.sample_off  <= 8'd9;
      timing.pre_gap     <= 8'd20;
      timing.timeout     <= 24'd1048575;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_SHORT:   timing.short_phase <= cfg.data.data[5:0];
        REG_PERIOD:  timing.period      <= cfg.data.data[7:0];
        REG_SAMPLE:  timing.sample_off  <= cfg.data.data[7:0];
        REG_GAP:     timing.pre_gap     <= cfg.data.data[7:0];
        REG_TIMEOUT: timing.timeout     <= cfg.data.data;
        default: ;
      endcase
    end
  end
endmodule

### test/tb_single_wire_debug_frame_master_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_single_wire_debug_frame_master_top
// self-checking bench for the single-wire debug frame master
// ----------------------------------------------------------------------------
// a behavioural copy of the frame sequencer predicts one result per accepted
// item; a target emulator chooses the line level of each tick from the
// predicted sequencer state, so frames are acknowledged, refused, resent,
// timed out and read back with good and broken headers and parity
// ----------------------------------------------------------------------------
module tb_single_wire_debug_frame_master_top;
  import swdfm_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 1750;
  localparam int DRAIN_CYCLES = 6;

  // sequencer phases of the predictor
  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_GAP, SEQ_TX, SEQ_ACKWAIT, SEQ_ACKSAMP,
    SEQ_RXWAIT, SEQ_RXSAMP, SEQ_RXTAIL, SEQ_RXACK
  } seq_phase_t;

  logic clk;
  logic rst;

  swdfm_if #(.payload_t(in_item_t))  in_ch ();
  swdfm_if #(.payload_t(out_item_t)) out_ch ();
  swdfm_if #(.payload_t(cfg_item_t)) cfg_ch ();

  single_wire_debug_frame_master_top #(.WRITE_DEPTH(256)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // timing registers as the predictor sees them
  logic [5:0]  t_short;
  logic [7:0]  t_period;
  logic [7:0]  t_sample;
  logic [7:0]  t_gap;
  logic [23:0] t_timeout;

  // predicted sequencer state
  seq_phase_t  seq_ph;
  int unsigned tick_cnt;
  int unsigned bit_idx;
  logic [9:0]  shift_reg;
  logic        par_acc;
  int unsigned frame_idx;
  logic [1:0]  cmd_op;
  logic [23:0] cmd_addr;
  logic [7:0]  cmd_count;
  logic [7:0]  load_ptr;
  logic [7:0]  wr_buffer [256];
  logic        line_last;
  logic        drive_level;
  out_item_t   res_now;

  out_item_t   expected_results [$];
  int          fail_count;
  int          items_sent;

  // stimulus knobs
  bit          idle_on;
  int          hold_request;
  bit          target_silent;
  bit          refuse_command;
  int          nack_pct;
  int          bad_header_pct;
  int          bad_parity_pct;
  logic        target_bit;

  // ---------------------------------------------------------------- predictor
  function automatic void end_command(logic [2:0] st);
    seq_ph = SEQ_IDLE;
    tick_cnt = 0;
    load_ptr = 0;
    res_now.done_res = 1'b1;
    res_now.status = st;
  endfunction

  // one tick of a bit waveform; ended flags the close of the bit period
  function automatic logic wave_step(logic b, output bit ended);
    int unsigned p, s, lo;
    logic d;
    p = (t_period == 0) ? 1 : t_period;
    s = (t_short > p) ? p : t_short;
    lo = b ? s : p - s;
    d = (tick_cnt < lo);
    tick_cnt++;
    ended = (tick_cnt >= p);
    return d;
  endfunction

  function automatic void frame_load();
    logic [8:0] v;
    case (frame_idx)
      0: v = {7'd0, cmd_op};
      1: v = {1'b0, cmd_count};
      2: v = {1'b0, cmd_addr[23:16]};
      3: v = {1'b0, cmd_addr[15:8]};
      4: v = {1'b0, cmd_addr[7:0]};
      default: v = {1'b0, wr_buffer[(frame_idx - 5) % 256]};
    endcase
    shift_reg = {1'b0, v};
    bit_idx = 0;
    par_acc = 0;
    tick_cnt = 0;
    seq_ph = SEQ_TX;
  endfunction

  function automatic logic tx_step();
    int unsigned n;
    logic b, d;
    bit e;
    n = (frame_idx == 0) ? 4 : 9;
    b = (bit_idx < n) ? shift_reg[n - 1 - bit_idx] : par_acc;
    d = wave_step(b, e);
    if (e) begin
      if (bit_idx < n) par_acc ^= b;
      bit_idx++;
      tick_cnt = 0;
      if (bit_idx > n) seq_ph = SEQ_ACKWAIT;
    end
    return d;
  endfunction

  function automatic void ack_taken(logic b);
    int unsigned total;
    total = (cmd_op == OP_RESET) ? 1 : ((cmd_op == OP_READ) ? 5 : 5 + cmd_count);
    tick_cnt = 0;
    if (b) begin
      frame_idx++;
      if (frame_idx < total) seq_ph = SEQ_GAP;
      else if (cmd_op == OP_READ && cmd_count > 0) begin
        seq_ph = SEQ_RXWAIT;
        bit_idx = 0;
      end else end_command(ST_OK);
    end else if (frame_idx == 0) end_command(ST_REFUSED);
    else seq_ph = SEQ_GAP;
  endfunction

  function automatic logic rxack_step();
    logic d;
    bit e;
    int unsigned idx;
    d = wave_step(~par_acc, e);
    if (e) begin
      if (par_acc) end_command(ST_PARITY);
      else begin
        idx = frame_idx - 5;
        res_now.read_valid = 1'b1;
        res_now.read_data = shift_reg[8:1];
        frame_idx = (frame_idx + 1) & 9'h1FF;
        res_now.read_last = (idx + 1 >= cmd_count);
        if (res_now.read_last) end_command(ST_OK);
        else begin
          seq_ph = SEQ_RXWAIT;
          tick_cnt = 0;
          bit_idx = 0;
        end
      end
    end
    return d;
  endfunction

  function automatic void edge_wait(logic line, seq_phase_t nxt);
    if (line_last && !line) begin
      seq_ph = nxt;
      tick_cnt = 0;
    end else begin
      tick_cnt++;
      if (tick_cnt >= t_timeout) end_command(ST_TIMEOUT);
    end
  endfunction

  function automatic bit sample_now();
    int unsigned off;
    off = (t_sample == 0) ? 1 : t_sample;
    tick_cnt++;
    return tick_cnt >= off;
  endfunction

  function automatic logic line_step(logic line);
    logic d;
    int unsigned p;
    d = 1'b0;
    case (seq_ph)
      SEQ_GAP: begin
        if (tick_cnt >= t_gap) begin
          frame_load();
          d = tx_step();
        end else tick_cnt++;
      end
      SEQ_TX: d = tx_step();
      SEQ_ACKWAIT: edge_wait(line, SEQ_ACKSAMP);
      SEQ_ACKSAMP: if (sample_now()) ack_taken(line);
      SEQ_RXWAIT: edge_wait(line, SEQ_RXSAMP);
      SEQ_RXSAMP: begin
        if (sample_now()) begin
          shift_reg = {shift_reg[8:0], line};
          bit_idx++;
          if (bit_idx == 1 && !line) end_command(ST_HEADER);
          else if (bit_idx < 10) begin
            seq_ph = SEQ_RXWAIT;
            tick_cnt = 0;
          end else begin
            par_acc = ^shift_reg[8:0];
            seq_ph = SEQ_RXTAIL;
          end
        end
      end
      SEQ_RXTAIL: begin
        p = (t_period == 0) ? 1 : t_period;
        tick_cnt++;
        if (tick_cnt >= p) begin
          seq_ph = SEQ_RXACK;
          tick_cnt = 0;
          d = rxack_step();
        end
      end
      SEQ_RXACK: d = rxack_step();
      default: seq_ph = SEQ_IDLE;
    endcase
    return d;
  endfunction

  // works out the result of one accepted item and updates the copy
  function automatic out_item_t predict_result(in_item_t it);
    res_now = '0;
    case (it.kind)
      KIND_TICK: begin
        drive_level = line_step(it.line_in);
        line_last = it.line_in;
      end
      KIND_LOAD: begin
        if (seq_ph == SEQ_IDLE) begin
          wr_buffer[load_ptr] = it.load_byte;
          load_ptr = load_ptr + 8'd1;
        end
      end
      KIND_START: begin
        if (seq_ph == SEQ_IDLE) begin
          if (it.opcode == OP_BAD) end_command(ST_REFUSED);
          else begin
            cmd_op = it.opcode;
            cmd_addr = it.target_address;
            cmd_count = it.byte_count;
            frame_idx = 0;
            tick_cnt = 0;
            seq_ph = SEQ_GAP;
          end
        end
      end
      default: ;
    endcase
    res_now.drive_low = drive_level;
    res_now.busy_res = (seq_ph != SEQ_IDLE);
    return res_now;
  endfunction

  // ---------------------------------------------------------------- drivers
  // inputs change on the falling edge; every task returns on a falling edge
  task automatic send_item(in_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data = it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_result(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    in_ch.valid = 1'b0;
    cfg_ch.data.index = idx;
    cfg_ch.data.data = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SHORT:   t_short = val[5:0];
      REG_PERIOD:  t_period = val[7:0];
      REG_SAMPLE:  t_sample = val[7:0];
      REG_GAP:     t_gap = val[7:0];
      REG_TIMEOUT: t_timeout = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // all results in, then the pipeline's own latency
  task automatic drain();
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_timing(int sh, int per, int smp, int gp, int tmo);
    drain();
    write_reg(REG_SHORT, 24'(sh));
    write_reg(REG_PERIOD, 24'(per));
    write_reg(REG_SAMPLE, 24'(smp));
    write_reg(REG_GAP, 24'(gp));
    write_reg(REG_TIMEOUT, 24'(tmo));
  endtask

  // line level the emulated target and the pull-up give for the next tick
  function automatic logic target_line();
    case (seq_ph)
      SEQ_ACKWAIT, SEQ_RXWAIT: begin
        if (target_silent || !line_last) return 1'b1;
        if (seq_ph == SEQ_ACKWAIT) begin
          if (frame_idx == 0) target_bit = !refuse_command;
          else target_bit = ($urandom_range(0, 99) >= nack_pct);
        end else if (bit_idx == 0) target_bit = ($urandom_range(0, 99) >= bad_header_pct);
        else if (bit_idx == 9)
          target_bit = ^shift_reg[7:0] ^ ($urandom_range(0, 99) < bad_parity_pct);
        else target_bit = 1'($urandom_range(0, 1));
        return 1'b0;
      end
      SEQ_ACKSAMP, SEQ_RXSAMP: return target_bit;
      default: return ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : !drive_level;
    endcase
  endfunction

  // item the block ignores while busy, or one with no effect at all
  function automatic in_item_t noise_item();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.target_address = 24'($urandom);
    if (seq_ph == SEQ_IDLE) it.kind = KIND_NONE;
    else it.kind = kind_t'($urandom_range(1, 3));
    return it;
  endfunction

  task automatic run_command(logic [1:0] op, logic [23:0] addr, logic [7:0] cnt);
    in_item_t it;
    // write data goes into the buffer first, from entry zero
    if (op == OP_WRITE) begin
      for (int k = 0; k < cnt; k++) begin
        it = '0;
        it.kind = KIND_LOAD;
        it.load_byte = 8'($urandom);
        it.line_in = 1'($urandom_range(0, 1));
        send_item(it);
      end
    end
    it = '0;
    it.kind = KIND_START;
    it.opcode = op;
    it.target_address = addr;
    it.byte_count = cnt;
    it.line_in = 1'b1;
    send_item(it);
    while (seq_ph != SEQ_IDLE) begin
      if ($urandom_range(0, 24) == 0) it = noise_item();
      else begin
        it = '0;
        it.kind = KIND_TICK;
        it.line_in = target_line();
      end
      send_item(it);
    end
  endtask

  // receiver side: random stalls and the long hold-off
  always @(negedge clk) begin : rx_ready_drive
    int hold_left;
    if (rst) begin
      hold_left = 0;
      out_ch.ready = 1'b1;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 7) == 0)
        hold_left = $urandom_range(1, 8);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else out_ch.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker
  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t e, a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("drive_low", e.drive_low, a.drive_low);
        check_field("busy_res", e.busy_res, a.busy_res);
        check_field("read_valid", e.read_valid, a.read_valid);
        check_field("read_data", e.read_data, a.read_data);
        check_field("read_last", e.read_last, a.read_last);
        check_field("done_res", e.done_res, a.done_res);
        check_field("status", e.status, a.status);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin : stall_watch
    int quiet;
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_default_timing();
    run_command(OP_RESET, 24'h000000, 8'd0);
    run_command(OP_BAD, 24'hFFFFFF, 8'd255);
  endtask

  task automatic test_timing_extremes();
    // short phase longer than the period, slowest sampling, no gap
    set_timing(63, 4, 255, 0, 24'hFFFFFF);
    run_command(OP_RESET, 24'd0, 8'd0);
    // longest gap
    set_timing(1, 8, 1, 255, 24'hFFFFFF);
    run_command(OP_RESET, 24'd0, 8'd0);
    set_timing(0, 0, 0, 0, 1000);
    run_command(OP_RESET, 24'd0, 8'd0);
    set_timing(1, 4, 1, 0, 1000);
  endtask

  task automatic test_write_frames();
    refuse_command = 1;
    run_command(OP_READ, 24'h123456, 8'd2);
    refuse_command = 0;
    nack_pct = 30;
    run_command(OP_WRITE, 24'h5A5A5A, 8'd1);
    nack_pct = 0;
  endtask

  task automatic test_read_frames();
    run_command(OP_READ, 24'h800000, 8'd2);
    bad_header_pct = 100;
    run_command(OP_READ, 24'h00FF00, 8'd1);
    bad_header_pct = 0;
    bad_parity_pct = 100;
    run_command(OP_READ, 24'h0000FF, 8'd1);
    bad_parity_pct = 0;
  endtask

  task automatic test_edge_timeout();
    set_timing(1, 4, 1, 0, 1);
    target_silent = 1;
    run_command(OP_RESET, 24'd0, 8'd0);
    target_silent = 0;
    set_timing(1, 4, 1, 0, 40);
    target_silent = 1;
    run_command(OP_READ, 24'h000020, 8'd2);
    target_silent = 0;
  endtask

  task automatic test_output_backpressure();
    set_timing(1, 4, 1, 0, 1000);
    hold_request = 300;
    run_command(OP_RESET, 24'h0F0F0F, 8'd0);
  endtask

  task automatic test_random_commands();
    int pick;
    logic [7:0] cnt;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - 300) idle_on = 0;
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(4, 12);
        set_timing($urandom_range(1, pick), pick, $urandom_range(1, pick),
                   $urandom_range(0, 8), $urandom_range(200, 2000));
      end
      nack_pct = $urandom_range(0, 1) ? 0 : 10;
      refuse_command = ($urandom_range(0, 29) == 0);
      bad_header_pct = ($urandom_range(0, 9) == 0) ? 20 : 0;
      bad_parity_pct = ($urandom_range(0, 9) == 0) ? 20 : 0;
      cnt = 8'($urandom_range(0, 6));
      pick = $urandom_range(0, 19);
      if (pick < 8) run_command(OP_READ, 24'($urandom), cnt);
      else if (pick < 16) run_command(OP_WRITE, 24'($urandom), cnt);
      else if (pick < 19) run_command(OP_RESET, 24'($urandom), cnt);
      else run_command(OP_BAD, 24'($urandom), cnt);
    end
    refuse_command = 0;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    fail_count = 0;
    items_sent = 0;
    idle_on = 1;
    hold_request = 0;
    target_silent = 0;
    refuse_command = 0;
    nack_pct = 0;
    bad_header_pct = 0;
    bad_parity_pct = 0;
    target_bit = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    // predictor reset state
    t_short = 2;
    t_period = 22;
    t_sample = 9;
    t_gap = 20;
    t_timeout = 24'd1048575;
    seq_ph = SEQ_IDLE;
    tick_cnt = 0;
    bit_idx = 0;
    shift_reg = '0;
    par_acc = 0;
    frame_idx = 0;
    cmd_op = '0;
    cmd_addr = '0;
    cmd_count = '0;
    load_ptr = '0;
    line_last = 1'b1;
    drive_level = 1'b0;
    rst = 1'b1;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_default_timing();
    test_timing_extremes();
    test_write_frames();
    test_read_frames();
    test_edge_timeout();
    test_output_backpressure();
    test_random_commands();

    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
